FILE: sv/light_timer_bank_assert.svh
// Assertion macros for the checker file of the light timer bank.
// Depends on nothing; included by bare file name.
`ifndef LIGHT_TIMER_BANK_ASSERT_SVH
`define LIGHT_TIMER_BANK_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define LTB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("light timer bank check failed");

// Next-cycle implication, disabled while reset is high.
`define LTB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("light timer bank check failed");

`endif

FILE: sv/ltb_pkg.sv
// Types and constants of the light timer bank.
// Depends on nothing; used by every design module of the block.
package ltb_pkg;

   localparam int TIME_W   = 20;
   localparam int STATUS_W = 8;
   localparam int RND_W    = 8;
   localparam int CNT_W    = 4;
   localparam int OP_W     = 2;
   localparam int IDX_W    = 3;

   localparam logic [TIME_W-1:0]   TIME_MAX    = 20'hFFFFF;
   localparam logic [TIME_W-1:0]   TEST_TIME   = 20'd999999;
   localparam logic [TIME_W-1:0]   DUR_RESET   = 20'd900500;
   localparam logic [STATUS_W-1:0] TEST_STATUS = 8'hFF;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 32;

   // Request opcodes.
   localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
   localparam logic [OP_W-1:0] OP_SET    = 2'd1;
   localparam logic [OP_W-1:0] OP_RANDOM = 2'd2;
   localparam logic [OP_W-1:0] OP_TEST   = 2'd3;

   // Timer file operations.
   localparam logic [1:0] TF_NOP  = 2'd0;
   localparam logic [1:0] TF_DEC  = 2'd1;
   localparam logic [1:0] TF_LOAD = 2'd2;

   typedef struct packed {
      logic [1:0]        op;
      logic [TIME_W-1:0] data;
   } tf_cmd_type;

endpackage

FILE: sv/ltb_mod_unit.sv
// Iterative remainder unit: 8-bit dividend modulo a small divisor, one bit per cycle.
// Depends on ltb_pkg.
module ltb_mod_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ltb_pkg::RND_W-1:0]   dividend,
   input  logic [ltb_pkg::CNT_W-1:0]   divisor,
   output logic                        done,
   output logic [ltb_pkg::CNT_W-1:0]   remainder
);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [2:0]                  step_ff, step_in;
   logic [ltb_pkg::RND_W-1:0]   quo_ff, quo_in;
   logic [ltb_pkg::CNT_W-1:0]   rem_ff, rem_in;
   logic [ltb_pkg::CNT_W-1:0]   div_ff, div_in;
   logic [ltb_pkg::CNT_W-1:0]   trial;

   // The remainder stays below the divisor (at most eight), so its top bit is free.
   assign trial = {rem_ff[ltb_pkg::CNT_W-2:0], quo_ff[ltb_pkg::RND_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[ltb_pkg::RND_W-2:0], 1'b0};
         rem_in  = (trial >= div_ff) ? trial - div_ff : trial;
         step_in = step_ff + 3'd1;
         if (step_ff == 3'd7) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

FILE: sv/ltb_timer_file.sv
// Timer registers with one shared decrement and zero-compare unit on a single access port.
// Depends on ltb_pkg.
module ltb_timer_file #(
   parameter int LIGHT_COUNT = 8,
   parameter int PTR_W       = 3
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ltb_pkg::tf_cmd_type            cmd,
   input  logic [PTR_W-1:0]               ptr,
   output logic [ltb_pkg::TIME_W-1:0]     rd_time,
   output logic                           rd_zero,
   output logic [ltb_pkg::STATUS_W-1:0]   lit_mask
);

   localparam logic [ltb_pkg::TIME_W-1:0] TIME_ONE = {{(ltb_pkg::TIME_W-1){1'b0}}, 1'b1};

   logic [ltb_pkg::TIME_W-1:0] timers_ff [LIGHT_COUNT];
   logic [LIGHT_COUNT-1:0]     lit_ff;
   logic [ltb_pkg::TIME_W-1:0] wr_time;
   logic                       wr_en;

   assign rd_time = timers_ff[ptr];
   assign rd_zero = (rd_time == '0);

   // The one arithmetic unit: decrement of the addressed timer, or a load.
   always_comb begin
      wr_en   = 1'b0;
      wr_time = cmd.data;
      case (cmd.op)
         ltb_pkg::TF_DEC: begin
            wr_en   = !rd_zero;
            wr_time = rd_time - TIME_ONE;
         end
         ltb_pkg::TF_LOAD: begin
            wr_en   = 1'b1;
         end
         default: begin
            wr_en   = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LIGHT_COUNT; i++) begin
            timers_ff[i] <= '0;
         end
         lit_ff <= '0;
      end else if (wr_en) begin
         timers_ff[ptr] <= wr_time;
         lit_ff[ptr]    <= (wr_time != '0);
      end
   end

   always_comb begin
      lit_mask                  = '0;
      lit_mask[LIGHT_COUNT-1:0] = lit_ff;
   end

endmodule

FILE: sv/light_timer_bank.sv
// Light timer bank: one transaction in, one result out. A set or test toggle needs no walk;
// a tick walks over the timers through the single timer-file port, and a random lighting
// walks once to count the off lights, waits for the 8-step remainder unit and walks again.
// One transaction is in work at a time; the result register frees the input.
// Reset (synchronous, active high) clears all timers, leaves test mode and loads the random
// lighting duration with 900500 ms; the input is not ready while reset is high.
module light_timer_bank #(
   parameter int LIGHT_COUNT = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // Input channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [2:0] light_index, [22:3] duration, [30:23] random_value, [31] zero.
   input  logic [ltb_pkg::REQ_DATA_W-1:0]      req_tdata,
   // [1:0] opcode.
   input  logic [ltb_pkg::OP_W-1:0]            req_tuser,
   // Result channel.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [7:0] status_byte, [27:8] time_left, [28] any_off, [29] all_off,
   // [30] no_light_free, [31] zero.
   output logic [ltb_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // Configuration: random_light_duration.
   input  logic                                csr_wen,
   input  logic [ltb_pkg::TIME_W-1:0]          csr_wdata
);

   localparam int PTR_W = (LIGHT_COUNT > 1) ? $clog2(LIGHT_COUNT) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(LIGHT_COUNT - 1);
   localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
   localparam logic [ltb_pkg::CNT_W-1:0] CNT_ONE = {{(ltb_pkg::CNT_W-1){1'b0}}, 1'b1};

   // Sequencer states.
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_TICK   = 3'd1;
   localparam logic [2:0] S_COUNT  = 3'd2;
   localparam logic [2:0] S_MOD    = 3'd3;
   localparam logic [2:0] S_PICK   = 3'd4;
   localparam logic [2:0] S_REPORT = 3'd5;

   // Unpacked request fields.
   logic [ltb_pkg::OP_W-1:0]   req_opcode;
   logic [ltb_pkg::IDX_W-1:0]  req_index;
   logic [ltb_pkg::TIME_W-1:0] req_duration;
   logic [ltb_pkg::RND_W-1:0]  req_random;

   assign req_opcode   = req_tuser;
   assign req_index    = req_tdata[2:0];
   assign req_duration = req_tdata[22:3];
   assign req_random   = req_tdata[30:23];

   logic [2:0]                  state_ff, state_in;
   logic [PTR_W-1:0]            ptr_ff, ptr_in;
   logic [ltb_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [ltb_pkg::CNT_W-1:0]   pick_ff, pick_in;
   logic [ltb_pkg::IDX_W-1:0]   idx_ff, idx_in;
   logic [ltb_pkg::RND_W-1:0]   rnd_ff, rnd_in;
   logic                        nofree_ff, nofree_in;
   logic                        test_ff, test_in;
   logic [ltb_pkg::TIME_W-1:0]  dur_ff, dur_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [ltb_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   ltb_pkg::tf_cmd_type         tf_cmd;
   logic [PTR_W-1:0]            tf_ptr;
   logic [ltb_pkg::TIME_W-1:0]  tf_time;
   logic                        tf_zero;
   logic [ltb_pkg::STATUS_W-1:0] lit_mask;

   logic                        mod_start;
   logic                        mod_done;
   logic [ltb_pkg::CNT_W-1:0]   mod_rem;

   logic                        accept;
   logic                        idx_ok;
   logic                        req_idx_ok;
   logic                        slot_free;
   logic [ltb_pkg::STATUS_W-1:0] status;
   logic [ltb_pkg::TIME_W-1:0]  time_left;

   assign req_tready = !reset && (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign idx_ok     = ({1'b0, idx_ff} < 4'(LIGHT_COUNT));
   assign req_idx_ok = ({1'b0, req_index} < 4'(LIGHT_COUNT));

   ltb_timer_file #(
      .LIGHT_COUNT (LIGHT_COUNT),
      .PTR_W       (PTR_W)
   ) u_timer_file (
      .clock    (clock),
      .reset    (reset),
      .cmd      (tf_cmd),
      .ptr      (tf_ptr),
      .rd_time  (tf_time),
      .rd_zero  (tf_zero),
      .lit_mask (lit_mask)
   );

   ltb_mod_unit u_mod_unit (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (rnd_ff),
      .divisor   (count_in),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // Sequencer. The timers are visited in index order through the single port
   // of the timer file; a tick decrements each, a random lighting first counts
   // the off lights, then waits for the remainder and walks again to the chosen one.
   always_comb begin
      state_in   = state_ff;
      ptr_in     = ptr_ff;
      count_in   = count_ff;
      pick_in    = pick_ff;
      idx_in     = idx_ff;
      rnd_in     = rnd_ff;
      nofree_in  = nofree_ff;
      test_in    = test_ff;
      tf_cmd.op  = ltb_pkg::TF_NOP;
      tf_cmd.data = req_duration;
      tf_ptr     = ptr_ff;
      mod_start  = 1'b0;

      case (state_ff)
         S_IDLE: begin
            tf_ptr = req_index[PTR_W-1:0];
            if (accept) begin
               idx_in    = req_index;
               rnd_in    = req_random;
               nofree_in = 1'b0;
               ptr_in    = '0;
               count_in  = '0;
               case (req_opcode)
                  ltb_pkg::OP_TICK: begin
                     state_in = S_TICK;
                  end
                  ltb_pkg::OP_SET: begin
                     // A set to a light that does not exist is dropped.
                     if (req_idx_ok) begin
                        tf_cmd.op = ltb_pkg::TF_LOAD;
                     end
                     state_in = S_REPORT;
                  end
                  ltb_pkg::OP_RANDOM: begin
                     state_in = S_COUNT;
                  end
                  default: begin
                     test_in  = !test_ff;
                     state_in = S_REPORT;
                  end
               endcase
            end
         end
         S_TICK: begin
            tf_cmd.op = ltb_pkg::TF_DEC;
            ptr_in    = ptr_ff + PTR_ONE;
            if (ptr_ff == PTR_LAST) begin
               state_in = S_REPORT;
            end
         end
         S_COUNT: begin
            count_in = count_ff + {3'd0, tf_zero};
            ptr_in   = ptr_ff + PTR_ONE;
            if (ptr_ff == PTR_LAST) begin
               if (count_in == '0) begin
                  // Every light is lit: nothing changes and the flag is raised.
                  nofree_in = 1'b1;
                  state_in  = S_REPORT;
               end else begin
                  mod_start = 1'b1;
                  state_in  = S_MOD;
               end
            end
         end
         S_MOD: begin
            ptr_in   = '0;
            count_in = '0;
            if (mod_done) begin
               pick_in  = mod_rem;
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            // count_ff now counts the off lights passed so far.
            tf_cmd.data = dur_ff;
            ptr_in      = ptr_ff + PTR_ONE;
            if (tf_zero) begin
               count_in = count_ff + CNT_ONE;
               if (count_ff == pick_ff) begin
                  tf_cmd.op = ltb_pkg::TF_LOAD;
                  state_in  = S_REPORT;
               end
            end
            if (ptr_ff == PTR_LAST) begin
               state_in = S_REPORT;
            end
         end
         S_REPORT: begin
            tf_ptr = idx_ff[PTR_W-1:0];
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result fields. Test mode masks the real status and time but not the flag.
   always_comb begin
      if (test_ff) begin
         status    = ltb_pkg::TEST_STATUS;
         time_left = ltb_pkg::TEST_TIME;
      end else begin
         status    = lit_mask;
         time_left = idx_ok ? tf_time : ltb_pkg::TIME_MAX;
      end
   end

   // Output register: loaded at the end of a transaction, emptied by the consumer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == S_REPORT) && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, nofree_ff, (status == '0),
                         (status != ltb_pkg::TEST_STATUS), time_left, status};
      end
   end

   assign dur_in = csr_wen ? csr_wdata : dur_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         test_ff      <= 1'b0;
         dur_ff       <= ltb_pkg::DUR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         test_ff      <= test_in;
         dur_ff       <= dur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff      <= ptr_in;
      count_ff    <= count_in;
      pick_ff     <= pick_in;
      idx_ff      <= idx_in;
      rnd_ff      <= rnd_in;
      nofree_ff   <= nofree_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: sv/ltb_checker.sv
// Port-level checks of the light timer bank, attached to the top level by a bind.
// Depends on light_timer_bank_assert.svh.
`include "light_timer_bank_assert.svh"

module ltb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // A held result keeps its value.
   `LTB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // Only one transaction is worked on at a time.
   `LTB_ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready)

   // The any-off flag follows the status byte.
   `LTB_ASSERT_NOW(a_any_off, clock, reset, rsp_tvalid, rsp_tdata[28] == (rsp_tdata[7:0] != 8'hFF))

   // The all-off flag follows the status byte.
   `LTB_ASSERT_NOW(a_all_off, clock, reset, rsp_tvalid, rsp_tdata[29] == (rsp_tdata[7:0] == 8'h00))

endmodule

bind light_timer_bank ltb_checker u_ltb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
